[hw/rtl/websocket_frame_deframer_macros.svh]
// Assertion helpers shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define WSFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
// next-cycle implication, disabled during reset
`define WSFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define WSFD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WSFD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/wsfd_pkg.sv]
package wsfd_pkg;

    // parse phases
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_MASK = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;

    // byte kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_MASK    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // flag bit positions
    localparam int FL_NOT_FINAL = 0;
    localparam int FL_RESERVED  = 1;
    localparam int FL_NOT_TEXT  = 2;
    localparam int FL_UNMASKED  = 3;
    localparam int FL_EXT_LEN   = 4;

    localparam logic [3:0] OPCODE_TEXT = 4'd1;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;

    typedef struct packed {
        logic [1:0] byte_kind;
        logic [7:0] data_out;
        logic       frame_end;
        logic [4:0] error_flags;
    } wsfd_result_t;

endpackage

[hw/rtl/wsfd_parser.sv]
`include "websocket_frame_deframer_macros.svh"

module wsfd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [7:0]            rx_byte,
    output wsfd_pkg::wsfd_result_t result
);
    import wsfd_pkg::*;

    logic [2:0]      phase_reg,   phase_next;
    logic [3:0][7:0] key_reg,     key_next;
    logic [1:0]      key_pos_reg, key_pos_next;
    logic [6:0]      rem_reg,     rem_next;
    logic [4:0]      flags_reg,   flags_next;

    always_comb
    begin
        phase_next   = phase_reg;
        key_next     = key_reg;
        key_pos_next = key_pos_reg;
        rem_next     = rem_reg;
        flags_next   = flags_reg;
        result.byte_kind = KIND_HEADER;
        result.data_out  = rx_byte;
        result.frame_end = 1'b0;
        unique case (phase_reg)
            PH_HDR1:
            begin
                if (!rx_byte[7])
                    flags_next[FL_UNMASKED] = 1'b1;
                if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64)
                    flags_next[FL_EXT_LEN] = 1'b1;
                rem_next     = rx_byte[6:0];
                key_pos_next = 2'd0;
                key_next     = '0;
                phase_next   = PH_MASK;
            end
            PH_MASK:
            begin
                result.byte_kind     = KIND_MASK;
                key_next[key_pos_reg] = rx_byte;
                key_pos_next         = key_pos_reg + 2'd1;
                if (key_pos_reg == 2'd3)
                begin
                    if (rem_reg == '0)
                    begin
                        result.frame_end = 1'b1;
                        phase_next       = PH_HDR0;
                    end
                    else
                        phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                result.byte_kind = KIND_PAYLOAD;
                result.data_out  = rx_byte ^ key_reg[key_pos_reg];
                key_pos_next     = key_pos_reg + 2'd1;
                if (rem_reg <= 7'd1)
                begin
                    rem_next         = '0;
                    result.frame_end = 1'b1;
                    phase_next       = PH_HDR0;
                end
                else
                    rem_next = rem_reg - 7'd1;
            end
            default:
            begin
                // first header byte: flags start afresh
                flags_next               = '0;
                flags_next[FL_NOT_FINAL] = ~rx_byte[7];
                flags_next[FL_RESERVED]  = |rx_byte[6:4];
                flags_next[FL_NOT_TEXT]  = (rx_byte[3:0] != OPCODE_TEXT);
                phase_next               = PH_HDR1;
            end
        endcase
        result.error_flags = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            key_reg     <= '0;
            key_pos_reg <= '0;
            rem_reg     <= '0;
            flags_reg   <= '0;
        end
        else if (en)
        begin
            phase_reg   <= phase_next;
            key_reg     <= key_next;
            key_pos_reg <= key_pos_next;
            rem_reg     <= rem_next;
            flags_reg   <= flags_next;
        end
    end

    `WSFD_ASSERT_IMP(a_phase_legal, clk, rst_n, 1'b1, phase_reg[2] == 1'b0)
    `WSFD_ASSERT_IMP(a_hdr_no_rem, clk, rst_n,
        phase_reg == PH_HDR0 || phase_reg == PH_HDR1, rem_reg == '0)
    `WSFD_ASSERT_NXT(a_key_done, clk, rst_n,
        en && phase_reg == PH_MASK && key_pos_reg == 2'd3,
        phase_reg == PH_HDR0 || phase_reg == PH_DATA)

endmodule

[hw/rtl/websocket_frame_deframer.sv]
// WebSocket client frame deframer.
// Input stream (s_axis_*): one received byte per request, client-to-server
// direction. Each byte is classified as header, mask key or payload; payload
// bytes are XOR-unmasked with the rotating 4-byte key.
// Output stream (m_axis_*): one request per input byte. tdata carries the
// unmasked (or raw) byte and the frame's sticky error flags, tuser the byte
// kind, tlast marks the last byte of a frame.
// The output is registered: it turns valid in the cycle after the input accept.
// Throughput: 1 byte per cycle while the output is not stalled; the parse
// state is a single register stage updated by short logic on each accepted byte.
// Stall: the output register holds its request while m_axis_tready is low;
// the input is still taken in the same cycle the held request leaves, so a
// stalled receiver only pauses the input while the output is full.
// Reset: async active low; parsing restarts at the first header byte,
// key, length count and flags clear, output is empty.
// Extended length codes (126/127) flag an error but are used as the byte count.
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_out, [12:8] error_flags, [15:13] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] byte_kind
    output logic        m_axis_tlast    // frame_end
);
    import wsfd_pkg::*;

    logic         accept;
    logic         out_valid_reg;
    wsfd_result_t res;
    wsfd_result_t out_reg;

    // new byte may enter whenever the output slot is empty or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wsfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (accept),
        .rx_byte (s_axis_tdata),
        .result  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.error_flags, out_reg.data_out};
    assign m_axis_tuser  = out_reg.byte_kind;
    assign m_axis_tlast  = out_reg.frame_end;

    `WSFD_ASSERT_IMP(a_kind_legal, clk, rst_n, m_axis_tvalid,
        m_axis_tuser == KIND_HEADER || m_axis_tuser == KIND_MASK ||
        m_axis_tuser == KIND_PAYLOAD)
    `WSFD_ASSERT_IMP(a_end_kind, clk, rst_n, m_axis_tvalid && m_axis_tlast,
        m_axis_tuser == KIND_MASK || m_axis_tuser == KIND_PAYLOAD)
    `WSFD_ASSERT_NXT(a_accept_fills, clk, rst_n, accept, m_axis_tvalid)

endmodule
